[rtl/slist_pkg.sv]
// Shared types and codes for the sorted list engine.
`timescale 1ns / 1ps

package slist_pkg;

  // Operation codes carried by an input beat.
  typedef enum logic [1:0] {
    OP_INSERT  = 2'd0,
    OP_DEL_ONE = 2'd1,
    OP_DEL_ALL = 2'd2
  } op_t;

  // Status codes returned with each result beat.
  typedef enum logic [1:0] {
    ST_DONE    = 2'd0,
    ST_FULL    = 2'd1,
    ST_NOMATCH = 2'd2
  } status_t;

  // Sequencer states.
  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_REPORT
  } state_t;

  // Command broadcast from the sequencer to every cell.
  typedef struct packed {
    logic ins;
    logic del;
  } cell_cmd_t;

  // Status returned from each cell to the sequencer.
  typedef struct packed {
    logic eq;
    logic last;
  } cell_stat_t;

  // Width of result count fields.
  localparam int unsigned COUNT_BITS = 5;

endpackage

[rtl/slist_cell.sv]
// One storage cell of the sorted list chain.
`timescale 1ns / 1ps

module slist_cell
  import slist_pkg::*;
#(
  parameter int unsigned VALUE_BITS = 32
) (
  input  logic                         clk,
  input  logic                         rst,
  input  cell_cmd_t                    cmd,
  input  logic signed [VALUE_BITS-1:0] key,
  input  logic signed [VALUE_BITS-1:0] left_entry,
  input  logic                         left_valid,
  input  logic                         left_take,
  input  logic signed [VALUE_BITS-1:0] right_entry,
  input  logic                         right_valid,
  output logic signed [VALUE_BITS-1:0] entry,
  output logic                         valid,
  output logic                         take,
  output cell_stat_t                   stat
);

  logic signed [VALUE_BITS-1:0] entry_next;
  logic                         valid_next;
  logic                         ge;

  // Local comparisons against the key held by the sequencer.
  always_comb begin
    take      = !valid || (key < entry);
    ge        = valid && !(entry < key);
    stat.eq   = valid && (entry == key);
    stat.last = valid && !right_valid;
  end

  // An insert shifts this cell right; a delete pulls the right neighbour in.
  always_comb begin
    entry_next = entry;
    valid_next = valid;
    if (cmd.ins && take) begin
      if (left_take) begin
        entry_next = left_entry;
        valid_next = left_valid;
      end else begin
        entry_next = key;
        valid_next = 1'b1;
      end
    end else if (cmd.del && ge) begin
      entry_next = right_entry;
      valid_next = right_valid;
    end
  end

  // The entry itself needs no reset; only the valid flag is cleared.
  always_ff @(posedge clk) begin
    entry <= entry_next;
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= valid_next;
    end
  end

endmodule

[rtl/sorted_list_engine_top.sv]
// Top level of the sorted list engine: sequencer, cell chain and result register.
//
// Usage: the input channel (in_valid, in_ready, op, value) carries one operation
// per beat: insert, delete the first equal entry, or delete all equal entries.
// The output channel (out_valid, out_ready, count, removed, status, smallest,
// largest) returns exactly one result beat per input beat, in order.
// The list lives in a chain of CAPACITY cells; each cell compares its entry
// with the key and swaps data with its neighbours in the same cycle.
// Sequence: an insert or single delete makes one chain step (S_EXEC), then a
// report step (S_REPORT) that loads the result register once it is free. A
// delete-all removes one matching entry per chain cycle, then makes a final check
// that finds no match before its report step.
// in_ready is high only while the sequencer is idle, so one item is in work at
// a time; a new beat is taken only after the last one has reached the result register.
// The result register sits apart from the sequencer: a new beat is taken while
// a result still waits, and the sequencer holds in its report step until the
// register is free when the receiver stalls.
// Reset (rst, synchronous) empties the list at once by clearing every cell's
// valid flag and the entry count; no clearing pass is needed.
`timescale 1ns / 1ps

module sorted_list_engine_top
  import slist_pkg::*;
#(
  parameter int unsigned CAPACITY   = 16,
  parameter int unsigned VALUE_BITS = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         op,
  input  logic signed [31:0] value,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [4:0]         count,
  output logic [4:0]         removed,
  output logic [1:0]         status,
  output logic signed [31:0] smallest,
  output logic signed [31:0] largest
);

  localparam int unsigned CNT_BITS = $clog2(CAPACITY + 1);

  state_t                       state, state_next;
  op_t                          op_q;
  logic signed [VALUE_BITS-1:0] key;
  logic [CNT_BITS-1:0]          entry_count, entry_count_next;
  logic [CNT_BITS-1:0]          removed_q, removed_q_next;
  status_t                      status_q, status_q_next;
  cell_cmd_t                    cmd;
  logic                         report;
  logic                         in_fire;
  logic                         full;
  logic                         any_eq;

  logic signed [VALUE_BITS-1:0] cell_entry [CAPACITY];
  logic [CAPACITY-1:0]          cell_valid;
  logic [CAPACITY-1:0]          cell_take;
  cell_stat_t                   cell_stat  [CAPACITY];

  logic signed [VALUE_BITS-1:0] low_entry;
  logic signed [VALUE_BITS-1:0] high_entry;

  assign in_ready = (state == S_IDLE);
  assign in_fire  = in_valid && in_ready;
  assign full     = (entry_count == CNT_BITS'(CAPACITY));

  // The cell chain; the ends see an empty neighbour.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic signed [VALUE_BITS-1:0] l_entry, r_entry;
    logic                         l_valid, l_take, r_valid;
    if (i == 0) begin : g_first
      assign l_entry = '0;
      assign l_valid = 1'b0;
      assign l_take  = 1'b0;
    end else begin : g_inner_l
      assign l_entry = cell_entry[i-1];
      assign l_valid = cell_valid[i-1];
      assign l_take  = cell_take[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign r_entry = '0;
      assign r_valid = 1'b0;
    end else begin : g_inner_r
      assign r_entry = cell_entry[i+1];
      assign r_valid = cell_valid[i+1];
    end
    slist_cell #(
      .VALUE_BITS (VALUE_BITS)
    ) u_cell (
      .clk         (clk),
      .rst         (rst),
      .cmd         (cmd),
      .key         (key),
      .left_entry  (l_entry),
      .left_valid  (l_valid),
      .left_take   (l_take),
      .right_entry (r_entry),
      .right_valid (r_valid),
      .entry       (cell_entry[i]),
      .valid       (cell_valid[i]),
      .take        (cell_take[i]),
      .stat        (cell_stat[i])
    );
  end

  // Gather match flags and the first and last held entries from the chain.
  always_comb begin
    any_eq     = 1'b0;
    high_entry = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      any_eq = any_eq | cell_stat[i].eq;
      if (cell_stat[i].last) begin
        high_entry = high_entry | cell_entry[i];
      end
    end
    low_entry = cell_valid[0] ? cell_entry[0] : '0;
  end

  // Sequencer state register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state, cell commands and bookkeeping.
  always_comb begin
    state_next       = state;
    cmd              = '0;
    report           = 1'b0;
    entry_count_next = entry_count;
    removed_q_next   = removed_q;
    status_q_next    = status_q;
    unique case (state)
      S_IDLE: begin
        if (in_fire) begin
          removed_q_next = '0;
          status_q_next  = ST_DONE;
          state_next     = S_EXEC;
        end
      end
      S_EXEC: begin
        unique case (op_q)
          OP_INSERT: begin
            if (full) begin
              status_q_next = ST_FULL;
            end else begin
              cmd.ins          = 1'b1;
              entry_count_next = entry_count + CNT_BITS'(1);
            end
            state_next = S_REPORT;
          end
          OP_DEL_ONE: begin
            if (any_eq) begin
              cmd.del          = 1'b1;
              entry_count_next = entry_count - CNT_BITS'(1);
              removed_q_next   = CNT_BITS'(1);
            end else begin
              status_q_next = ST_NOMATCH;
            end
            state_next = S_REPORT;
          end
          OP_DEL_ALL: begin
            // One equal entry leaves the chain per cycle until none is left.
            if (any_eq) begin
              cmd.del          = 1'b1;
              entry_count_next = entry_count - CNT_BITS'(1);
              removed_q_next   = removed_q + CNT_BITS'(1);
            end else begin
              if (removed_q == '0) begin
                status_q_next = ST_NOMATCH;
              end
              state_next = S_REPORT;
            end
          end
          default: begin
            state_next = S_REPORT;
          end
        endcase
      end
      S_REPORT: begin
        if (!out_valid || out_ready) begin
          report     = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Operation registers and entry count.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      op_q <= op_t'(op);
      key  <= VALUE_BITS'(value);
    end
    removed_q <= removed_q_next;
    status_q  <= status_q_next;
    if (rst) begin
      entry_count <= '0;
    end else begin
      entry_count <= entry_count_next;
    end
  end

  // Result register; it is reloaded only once the previous beat has gone.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (report) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
    if (report) begin
      count    <= COUNT_BITS'(entry_count);
      removed  <= COUNT_BITS'(removed_q);
      status   <= status_q;
      smallest <= 32'(low_entry);
      largest  <= 32'(high_entry);
    end
  end

`ifndef SYNTHESIS
  // The number of set valid flags in the chain always equals the count.
  a_valid_matches_count: assert property (@(posedge clk) disable iff (rst)
    $countones(cell_valid) == int'(entry_count))
    else $error("cell valid flags disagree with entry count");

  // The count never exceeds the capacity.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    entry_count <= CNT_BITS'(CAPACITY))
    else $error("entry count beyond capacity");

  // An accepted beat always moves the sequencer into execution.
  a_accept_exec: assert property (@(posedge clk) disable iff (rst)
    in_fire |=> state == S_EXEC)
    else $error("accepted beat did not start execution");

  // A dropped insert never changes the count.
  a_full_holds: assert property (@(posedge clk) disable iff (rst)
    (state == S_EXEC && op_q == OP_INSERT && full) |=> full)
    else $error("insert into full store changed the count");
`endif

endmodule

[tb/tb_top.sv]
// Self-checking testbench for the sorted list engine, with its own shadow list as predictor.
`timescale 1ns / 1ps

module tb_top;
  import slist_pkg::*;

  localparam int LIST_DEPTH = 16;
  // The op field is two bits wide; this code is not used by the engine.
  localparam logic [1:0] OP_SPARE = 2'd3;
  localparam int STALL_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 40;
  localparam int HOLD_CYCLES = 150;

  typedef struct {
    logic [4:0]         count;
    logic [4:0]         removed;
    status_t            status;
    logic signed [31:0] smallest;
    logic signed [31:0] largest;
  } list_result_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [1:0]         op = OP_INSERT;
  logic signed [31:0] value = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [4:0]         count;
  logic [4:0]         removed;
  logic [1:0]         status;
  logic signed [31:0] smallest;
  logic signed [31:0] largest;

  // Shadow copy of the list, kept in ascending order.
  logic signed [31:0] shadow_list [LIST_DEPTH];
  int                 shadow_count = 0;
  list_result_t       pending_results [$];

  int mismatches = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_left = 0;
  bit hold_req = 1'b0;
  bit hold_done = 1'b0;
  int stall_cycles;

  sorted_list_engine_top u_top (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .op        (op),
    .value     (value),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .count     (count),
    .removed   (removed),
    .status    (status),
    .smallest  (smallest),
    .largest   (largest)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Apply one operation to the shadow list and return the result it should give.
  function automatic list_result_t predict_list_op(input logic [1:0] op_code,
                                                   input logic signed [31:0] operand);
    list_result_t r;
    int pos;
    int k;
    r.removed = '0;
    r.status  = ST_DONE;
    case (op_code)
      OP_INSERT: begin
        if (shadow_count >= LIST_DEPTH) begin
          r.status = ST_FULL;
        end else begin
          // Equal entries stay ahead of the new one.
          pos = 0;
          while (pos < shadow_count && !(operand < shadow_list[pos])) pos++;
          for (k = shadow_count; k > pos; k--) shadow_list[k] = shadow_list[k - 1];
          shadow_list[pos] = operand;
          shadow_count++;
        end
      end
      OP_DEL_ONE: begin
        pos = 0;
        while (pos < shadow_count && shadow_list[pos] != operand) pos++;
        if (pos < shadow_count) begin
          for (k = pos; k + 1 < shadow_count; k++) shadow_list[k] = shadow_list[k + 1];
          shadow_count--;
          r.removed = 5'd1;
        end else begin
          r.status = ST_NOMATCH;
        end
      end
      OP_DEL_ALL: begin
        k = 0;
        for (pos = 0; pos < shadow_count; pos++) begin
          if (shadow_list[pos] == operand) begin
            r.removed++;
          end else begin
            shadow_list[k] = shadow_list[pos];
            k++;
          end
        end
        shadow_count = k;
        if (r.removed == 0) r.status = ST_NOMATCH;
      end
      default: ;
    endcase
    r.count = 5'(shadow_count);
    if (shadow_count > 0) begin
      r.smallest = shadow_list[0];
      r.largest  = shadow_list[shadow_count - 1];
    end else begin
      r.smallest = '0;
      r.largest  = '0;
    end
    return r;
  endfunction

  // Pick an operand: often one already held, otherwise near zero, a corner or anything.
  function automatic logic signed [31:0] pick_operand(input bit want_held);
    int sel;
    if (want_held && shadow_count > 0) return shadow_list[$urandom_range(0, shadow_count - 1)];
    sel = $urandom_range(0, 99);
    if (sel < 15) return $urandom;
    if (sel < 25) begin
      case ($urandom_range(0, 3))
        0:       return 32'sh7FFF_FFFF;
        1:       return 32'sh8000_0000;
        2:       return 32'sd0;
        default: return -32'sd1;
      endcase
    end
    return $urandom_range(0, 24) - 12;
  endfunction

  // Offer one beat, with random gaps before it, and record its expected result once taken.
  task automatic send_op(input logic [1:0] op_code, input logic signed [31:0] operand);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    op       <= op_code;
    value    <= operand;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pending_results.push_back(predict_list_op(op_code, operand));
  endtask

  // Random operations; the insert share changes every 20 beats so the fill level wanders.
  task automatic run_mixed_traffic(input int items);
    int insert_bias;
    int roll;
    logic [1:0] op_code;
    logic signed [31:0] operand;
    insert_bias = 50;
    for (int n = 0; n < items; n++) begin
      if (n % 20 == 0) begin
        case ($urandom_range(0, 2))
          0:       insert_bias = 15;
          1:       insert_bias = 50;
          default: insert_bias = 85;
        endcase
      end
      roll = $urandom_range(0, 99);
      if (roll < insert_bias) begin
        op_code = OP_INSERT;
        operand = pick_operand($urandom_range(0, 9) < 3);
      end else begin
        roll = $urandom_range(0, 9);
        if (roll < 4) op_code = OP_DEL_ONE;
        else if (roll < 9) op_code = OP_DEL_ALL;
        else op_code = OP_SPARE;
        operand = pick_operand($urandom_range(0, 9) < 7);
      end
      send_op(op_code, operand);
    end
  endtask

  // Fill the store with one value, overflow it, then clear it with a single delete-all.
  task automatic test_full_store();
    for (int n = 0; n < LIST_DEPTH; n++) send_op(OP_INSERT, -32'sd7);
    send_op(OP_INSERT, 32'sd5);
    send_op(OP_DEL_ALL, -32'sd7);
  endtask

  // Empty-store cases, extreme values, duplicates, misses and the unused code.
  task automatic test_edge_values();
    send_op(OP_DEL_ONE, 32'sd3);
    send_op(OP_DEL_ALL, 32'sd3);
    send_op(OP_SPARE, 32'sd3);
    send_op(OP_INSERT, 32'sh7FFF_FFFF);
    send_op(OP_INSERT, 32'sh8000_0000);
    send_op(OP_INSERT, 32'sd0);
    send_op(OP_INSERT, -32'sd1);
    send_op(OP_INSERT, 32'sd0);
    send_op(OP_SPARE, 32'sh7FFF_FFFF);
    send_op(OP_DEL_ONE, 32'sd0);
    send_op(OP_DEL_ALL, 32'sd12345);
    send_op(OP_DEL_ONE, 32'sh8000_0000);
    send_op(OP_DEL_ALL, 32'sh7FFF_FFFF);
    send_op(OP_DEL_ALL, -32'sd1);
    send_op(OP_DEL_ALL, 32'sd0);
  endtask

  // Random traffic under the given sender and receiver idling percentages.
  task automatic test_random_traffic(input int sender_pct, input int receiver_pct,
                                     input int items);
    send_idle_pct = sender_pct;
    recv_idle_pct = receiver_pct;
    run_mixed_traffic(items);
  endtask

  // The receiver holds off for a long stretch while beats keep being offered.
  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_req = 1'b1;
    run_mixed_traffic(12);
  endtask

  // Result side: random stalls, or a counted hold-off once one is requested.
  always @(posedge clk) begin
    if (hold_req && !hold_done) begin
      hold_done = 1'b1;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left--;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // Compare each result beat with the oldest expectation.
  always @(posedge clk) begin
    list_result_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: count %0d removed %0d status %0d smallest %0d largest %0d",
                   count, removed, status, smallest, largest);
      end else begin
        want = pending_results.pop_front();
        if (count !== want.count || removed !== want.removed || status !== want.status ||
            smallest !== want.smallest || largest !== want.largest) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("mismatch: want count %0d removed %0d status %0d smallest %0d largest %0d",
                     want.count, want.removed, want.status, want.smallest, want.largest);
            $display("          got  count %0d removed %0d status %0d smallest %0d largest %0d",
                     count, removed, status, smallest, largest);
          end
        end
      end
    end
  end

  // Watchdog: too long without any beat on either channel ends the run.
  initial begin
    stall_cycles = 0;
    while (stall_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) stall_cycles = 0;
      else stall_cycles++;
    end
    $display("tb_top: done, errors");
    $finish;
  end

  // Test sequence.
  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    test_full_store();
    test_edge_values();
    test_random_traffic(22, 49, 140);
    test_backpressure();
    test_random_traffic(49, 22, 140);
    test_random_traffic(0, 0, 130);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule
